// ----- hw/rtl/sobel_gradient_3x3_core_assert.svh -----
// Assertion macros shared by the RTL. Clock and reset are the design's own names.
`ifndef SOBEL_GRADIENT_3X3_CORE_ASSERT_SVH
`define SOBEL_GRADIENT_3X3_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SGC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SGC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SGC_ASSERT_IMP(lbl, ante, cons)
`define SGC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/sobel_pkg.sv -----
package sobel_pkg;

   localparam int CSR_W      = 12;
   localparam int CSR_IDX_W  = 1;
   localparam int PIX_W      = 8;
   localparam int SUM_W      = PIX_W + 2;
   localparam int GRAD_W     = 11;
   localparam int POS_W      = 11;
   localparam int NUM_SLOTS  = 4;

   localparam int DEFAULT_MAX_COLS = 2048;
   localparam int DEFAULT_MAX_ROWS = 2048;

   localparam logic [CSR_W-1:0] RESET_IMAGE_COLS = CSR_W'(640);
   localparam logic [CSR_W-1:0] RESET_IMAGE_ROWS = CSR_W'(480);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_COLS = 1'b0,
      CSR_IMAGE_ROWS = 1'b1
   } csr_index_type;

endpackage

// ----- hw/rtl/sobel_gradient_3x3_core.sv -----
// Channel   Handshake               Payload
// req       req_valid / req_stall   req_pixel, req_frame_start
// rsp       rsp_valid / rsp_stall   rsp_grad_x, rsp_grad_y, rsp_out_col, rsp_out_row,
//                                   rsp_last_of_run, rsp_frame_done
// csr       csr_write               csr_index, csr_wdata
//
// One request per cycle while rsp_stall is low and each request yields at most one result;
// a request that yields n results (up to four) holds off the next until the last is loaded.
// From request accept to rsp_valid: memory read, window and result registers, in order.
// The line memory has one read and one write port; back-to-back reads of the same
// column (one-pixel-wide image) are forwarded.
// Reset is synchronous; no clearing pass, rows above row 0 are read only after written.
// A stalled result holds the emitter, which holds the window stage and then req_stall.
`include "sobel_gradient_3x3_core_assert.svh"

module sobel_gradient_3x3_core
   import sobel_pkg::*;
#(
   parameter int MAX_COLS = DEFAULT_MAX_COLS,
   parameter int MAX_ROWS = DEFAULT_MAX_ROWS
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     csr_write,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]         csr_wdata,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [PIX_W-1:0]         req_pixel,
   input  logic                     req_frame_start,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [GRAD_W-1:0] rsp_grad_x,
   output logic signed [GRAD_W-1:0] rsp_grad_y,
   output logic [POS_W-1:0]         rsp_out_col,
   output logic [POS_W-1:0]         rsp_out_row,
   output logic                     rsp_last_of_run,
   output logic                     rsp_frame_done
);

   localparam int ColW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RowW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int ColSzW = ($clog2(MAX_COLS + 1) > CSR_W) ? $clog2(MAX_COLS + 1) : CSR_W;
   localparam int RowSzW = ($clog2(MAX_ROWS + 1) > CSR_W) ? $clog2(MAX_ROWS + 1) : CSR_W;
   localparam int WordW  = 2 * PIX_W;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [ColW-1:0]  col;
      logic [RowW-1:0]  row;
      logic             r_ge1;
      logic             r_ge2;
      logic             c_zero;
      logic             c_last;
      logic             r_last;
   } a_stage_type;

   // configuration
   logic [CSR_W-1:0] image_cols_ff;
   logic [CSR_W-1:0] image_rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_cols_ff <= RESET_IMAGE_COLS;
         image_rows_ff <= RESET_IMAGE_ROWS;
      end else if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_COLS: image_cols_ff <= csr_wdata;
            CSR_IMAGE_ROWS: image_rows_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [ColSzW-1:0] ncols;
   logic [RowSzW-1:0] nrows;

   always_comb begin
      ncols = ColSzW'(image_cols_ff);
      if (ncols == '0) ncols = ColSzW'(1);
      else if (ncols > ColSzW'(MAX_COLS)) ncols = ColSzW'(MAX_COLS);
      nrows = RowSzW'(image_rows_ff);
      if (nrows == '0) nrows = RowSzW'(1);
      else if (nrows > RowSzW'(MAX_ROWS)) nrows = RowSzW'(MAX_ROWS);
   end

   // position tracking, request stage
   logic [ColW-1:0]   col_pos_ff, col_pos_in;
   logic [RowW-1:0]   row_pos_ff, row_pos_in;
   logic              req_take;
   logic              b_go;
   a_stage_type       a_ff, a_in;
   logic              a_valid_ff;

   assign req_stall = a_valid_ff && !b_go;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      logic [ColW-1:0]   c0;
      logic [RowW-1:0]   r0;
      logic [RowSzW-1:0] r1;
      logic [ColSzW-1:0] c_inc;
      logic [RowSzW-1:0] r_inc;
      c0 = req_frame_start ? '0 : col_pos_ff;
      r0 = req_frame_start ? '0 : row_pos_ff;
      r1 = RowSzW'(r0);
      a_in.col = c0;
      if (ColSzW'(c0) >= ncols) begin
         a_in.col = '0;
         r1 = RowSzW'(r0) + RowSzW'(1);
      end
      a_in.row    = (r1 >= nrows) ? '0 : RowW'(r1);
      a_in.pixel  = req_pixel;
      a_in.r_ge1  = (a_in.row != '0);
      a_in.r_ge2  = (a_in.row > RowW'(1));
      a_in.c_zero = (a_in.col == '0);
      a_in.c_last = (ColSzW'(a_in.col) == ncols - ColSzW'(1));
      a_in.r_last = (RowSzW'(a_in.row) == nrows - RowSzW'(1));
      c_inc = ColSzW'(a_in.col) + ColSzW'(1);
      r_inc = RowSzW'(a_in.row) + RowSzW'(1);
      if (c_inc >= ncols) begin
         col_pos_in = '0;
         row_pos_in = (r_inc >= nrows) ? '0 : RowW'(r_inc);
      end else begin
         col_pos_in = ColW'(c_inc);
         row_pos_in = a_in.row;
      end
   end

   // line memory: {older row, previous row} per column
   logic [WordW-1:0] line_mem [MAX_COLS];
   logic [WordW-1:0] mem_rd_ff;
   logic [WordW-1:0] wr_word;
   logic             fwd_ff;
   logic [WordW-1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (b_go) begin
         line_mem[a_ff.col] <= wr_word;
      end
      if (req_take) begin
         mem_rd_ff   <= line_mem[a_in.col];
         fwd_data_ff <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         a_valid_ff <= 1'b0;
         fwd_ff     <= 1'b0;
      end else begin
         if (req_take) begin
            col_pos_ff <= col_pos_in;
            row_pos_ff <= row_pos_in;
            fwd_ff     <= b_go && (a_ff.col == a_in.col);
         end
         if (req_take) a_valid_ff <= 1'b1;
         else if (b_go) a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) a_ff <= a_in;
   end

   // window stage
   logic [PIX_W-1:0] prev_rd, older_rd;
   logic [PIX_W-1:0] a0, a1, a2;
   logic [PIX_W-1:0] win_ff [3][3];

   assign prev_rd  = fwd_ff ? fwd_data_ff[PIX_W-1:0]     : mem_rd_ff[PIX_W-1:0];
   assign older_rd = fwd_ff ? fwd_data_ff[WordW-1:PIX_W] : mem_rd_ff[WordW-1:PIX_W];
   assign a2       = a_ff.pixel;
   assign a1       = a_ff.r_ge1 ? prev_rd : a_ff.pixel;
   assign a0       = a_ff.r_ge2 ? older_rd : a1;
   assign wr_word  = {prev_rd, a_ff.pixel};

   always_ff @(posedge clock) begin
      if (b_go) begin
         if (a_ff.c_zero) begin
            win_ff[0] <= '{a0, a1, a2};
            win_ff[1] <= '{a0, a1, a2};
         end else begin
            win_ff[0] <= win_ff[1];
            win_ff[1] <= win_ff[2];
         end
         win_ff[2] <= '{a0, a1, a2};
      end
   end

   // result emitter
   logic [NUM_SLOTS-1:0] e_mask_ff, e_mask_in;
   logic [ColW-1:0]      e_col_ff;
   logic [RowW-1:0]      e_row_ff;
   logic [NUM_SLOTS-1:0] e_sel, e_rest;
   logic                 out_load;
   logic                 e_free;

   assign e_sel    = e_mask_ff & (~e_mask_ff + NUM_SLOTS'(1));
   assign e_rest   = e_mask_ff & ~e_sel;
   assign out_load = (e_mask_ff != '0) && (!rsp_valid || !rsp_stall);
   assign e_free   = (e_mask_ff == '0) || (out_load && e_rest == '0);
   assign b_go     = a_valid_ff && e_free;

   always_comb begin
      e_mask_in[0] = a_ff.r_ge1 && !a_ff.c_zero;
      e_mask_in[1] = a_ff.r_ge1 && a_ff.c_last;
      e_mask_in[2] = a_ff.r_last && !a_ff.c_zero;
      e_mask_in[3] = a_ff.r_last && a_ff.c_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_mask_ff <= '0;
      end else if (b_go) begin
         e_mask_ff <= e_mask_in;
      end else if (out_load) begin
         e_mask_ff <= e_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (b_go) begin
         e_col_ff <= a_ff.col;
         e_row_ff <= a_ff.row;
      end
   end

   logic signed [GRAD_W-1:0] grad_x_in, grad_y_in;
   logic [POS_W-1:0]         col_in, row_in;

   always_comb begin
      logic             hi_col, lo_row;
      logic [1:0]       li, mi, ti, ni;
      logic [SUM_W-1:0] s_l, s_r, s_t, s_b;
      hi_col = e_sel[1] || e_sel[3];
      lo_row = e_sel[2] || e_sel[3];
      li = hi_col ? 2'd1 : 2'd0;
      mi = hi_col ? 2'd2 : 2'd1;
      ti = lo_row ? 2'd1 : 2'd0;
      ni = lo_row ? 2'd2 : 2'd1;
      s_l = SUM_W'(win_ff[li][ti]) + {1'b0, win_ff[li][ni], 1'b0} + SUM_W'(win_ff[li][2]);
      s_r = SUM_W'(win_ff[2][ti])  + {1'b0, win_ff[2][ni], 1'b0}  + SUM_W'(win_ff[2][2]);
      s_t = SUM_W'(win_ff[li][ti]) + {1'b0, win_ff[mi][ti], 1'b0} + SUM_W'(win_ff[2][ti]);
      s_b = SUM_W'(win_ff[li][2])  + {1'b0, win_ff[mi][2], 1'b0}  + SUM_W'(win_ff[2][2]);
      grad_x_in = $signed({1'b0, s_r}) - $signed({1'b0, s_l});
      grad_y_in = $signed({1'b0, s_b}) - $signed({1'b0, s_t});
      col_in = POS_W'(hi_col ? e_col_ff : e_col_ff - ColW'(1));
      row_in = POS_W'(lo_row ? e_row_ff : e_row_ff - RowW'(1));
   end

   logic                     rsp_valid_ff;
   logic signed [GRAD_W-1:0] rsp_grad_x_ff, rsp_grad_y_ff;
   logic [POS_W-1:0]         rsp_col_ff, rsp_row_ff;
   logic                     rsp_last_ff, rsp_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_grad_x_ff <= grad_x_in;
         rsp_grad_y_ff <= grad_y_in;
         rsp_col_ff    <= col_in;
         rsp_row_ff    <= row_in;
         rsp_last_ff   <= (e_rest == '0);
         rsp_done_ff   <= e_sel[3];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_grad_x      = rsp_grad_x_ff;
   assign rsp_grad_y      = rsp_grad_y_ff;
   assign rsp_out_col     = rsp_col_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_frame_done  = rsp_done_ff;

   `SGC_ASSERT_IMP(a_stall_needs_full, req_stall, a_valid_ff)
   `SGC_ASSERT_NEXT(a_holds_until_go, a_valid_ff && !b_go, a_valid_ff)
   `SGC_ASSERT_IMP(done_is_last, rsp_valid_ff && rsp_done_ff, rsp_last_ff)
   `SGC_ASSERT_IMP(more_pending, rsp_valid_ff && !rsp_last_ff, e_mask_ff != '0)

endmodule
